@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Each macro takes a label, the clock and the active-low reset, then the terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ensc_pkg.sv @@
// Package for the sensor compensation block: channel item types, register codes,
// constants of the compensation formulae and the divider sideband type. No dependencies.
`default_nettype none

package ensc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W      = 64;

    localparam logic [33:0] TF_OFFS_P  = 34'd128000;
    localparam logic [63:0] PRESS_K    = 64'd3125;
    localparam logic [20:0] PRESS_BASE = 21'd1048576;
    localparam logic [31:0] TF_OFFS_H  = 32'd76800;
    localparam logic [31:0] HUM_BIAS   = 32'd2097152;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP     = 3'd0,
        REG_PRESS_LO = 3'd1,
        REG_PRESS_HI = 3'd2,
        REG_MIXED    = 3'd3,
        REG_HUM      = 3'd4
    } ensc_reg_t;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } ensc_sample_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               press_ok;
        logic [16:0]        hum_q22_10;
    } ensc_result_t;

    // Travels alongside the quotient through the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        ok;
        logic        neg;
    } ensc_side_t;

endpackage

`default_nettype wire

@@ rtl/ensc_chan_if.sv @@
// Valid/ready channel interface carrying one item of payload type T.
// Used by the sensor compensation top level for its sample and result channels.
`default_nettype none

interface ensc_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/ensc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
// Depends on ensc_pkg for the word width and the sideband type.
`default_nettype none

module ensc_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [63:0]             dividend,
    input  wire logic [63:0]             divisor,
    input  wire ensc_pkg::ensc_side_t    side_in,
    output logic                         out_valid,
    output logic [63:0]                  quotient,
    output ensc_pkg::ensc_side_t         side_out
);
    import ensc_pkg::*;

    localparam int STEPS = DIV_W;

    logic             v_reg    [0:STEPS];
    logic [DIV_W-1:0] rem_reg  [0:STEPS-1];
    logic [DIV_W-1:0] dq_reg   [0:STEPS];
    logic [DIV_W-1:0] d_reg    [0:STEPS-1];
    ensc_side_t       side_reg [0:STEPS];

    logic [DIV_W:0]   sh   [0:STEPS-1];
    logic [DIV_W+1:0] diff [0:STEPS-1];
    logic             ge   [0:STEPS-1];

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            sh[k]   = {rem_reg[k], dq_reg[k][DIV_W-1]};
            diff[k] = {1'b0, sh[k]} - {2'b00, d_reg[k]};
            ge[k]   = !diff[k][DIV_W+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < STEPS; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            dq_reg[0]   <= dividend;
            d_reg[0]    <= divisor;
            side_reg[0] <= side_in;
            for (int k = 0; k < STEPS; k++)
            begin
                if (k < STEPS - 1)
                begin
                    rem_reg[k+1] <= ge[k] ? diff[k][DIV_W-1:0] : sh[k][DIV_W-1:0];
                    d_reg[k+1]   <= d_reg[k];
                end
                dq_reg[k+1]   <= {dq_reg[k][DIV_W-2:0], ge[k]};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign quotient  = dq_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

`default_nettype wire

@@ rtl/env_sensor_compensation.sv @@
// Integer compensation of a combined temperature, pressure and humidity sensor. One raw
// sample enters per cycle and one result leaves per cycle while the result side does not
// stall. Most of the pipeline is the pressure divider (an input register, then 64 stages of
// one quotient bit each), with eight stages ahead of it and six after it including the
// output register. A stall at the result side freezes the whole pipeline. Coefficients are
// read straight from the configuration registers at each stage, so they are to be written
// only while the pipeline is empty; the block itself does not enforce this.
// Depends on ensc_pkg, ensc_chan_if and ensc_div.
`default_nettype none

module env_sensor_compensation (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ensc_chan_if.sink                              sample,
    ensc_chan_if.source                            result,
    input  wire logic                              cfg_we,
    input  wire logic [ensc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ensc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ensc_pkg::*;

    // Configuration registers and coefficient fields
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [47:0] mixed_reg;
    logic [31:0] hum_coeffs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_lo_reg    <= '0;
            press_hi_reg    <= '0;
            mixed_reg       <= '0;
            hum_coeffs_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ensc_reg_t'(cfg_index))
                REG_TEMP:     temp_coeffs_reg <= cfg_wdata[47:0];
                REG_PRESS_LO: press_lo_reg    <= cfg_wdata;
                REG_PRESS_HI: press_hi_reg    <= cfg_wdata;
                REG_MIXED:    mixed_reg       <= cfg_wdata[47:0];
                REG_HUM:      hum_coeffs_reg  <= cfg_wdata[31:0];
                default:      ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = temp_coeffs_reg[31:16];
    assign t3 = temp_coeffs_reg[47:32];
    assign p1 = press_lo_reg[15:0];
    assign p2 = press_lo_reg[31:16];
    assign p3 = press_lo_reg[47:32];
    assign p4 = press_lo_reg[63:48];
    assign p5 = press_hi_reg[15:0];
    assign p6 = press_hi_reg[31:16];
    assign p7 = press_hi_reg[47:32];
    assign p8 = press_hi_reg[63:48];
    assign p9 = mixed_reg[15:0];
    assign h1 = mixed_reg[23:16];
    assign h2 = mixed_reg[39:24];
    assign h3 = mixed_reg[47:40];
    assign h4 = hum_coeffs_reg[11:0];
    assign h5 = hum_coeffs_reg[23:12];
    assign h6 = hum_coeffs_reg[31:24];

    // Pipeline advance: everything moves unless a finished result is held up.
    logic         out_valid_reg;
    ensc_result_t out_data_reg;
    logic         adv;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Stage 1: temperature products
    logic [31:0]        s1_a, s1_b, s1_bb;
    logic signed [47:0] s1_at2;

    assign s1_a   = {15'd0, sample.data.raw_temp[19:3]} - {15'd0, t1, 1'b0};
    assign s1_b   = {16'd0, sample.data.raw_temp[19:4]} - {16'd0, t1};
    assign s1_at2 = $signed(s1_a) * t2;
    assign s1_bb  = s1_b * s1_b;

    logic        s1_valid_reg;
    logic [31:0] s1_var1p_reg, s1_bb_reg;
    logic [19:0] s1_press_reg;
    logic [15:0] s1_hum_reg;

    // Stage 2
    logic [31:0]        s2_var1, s2_bb12;
    logic signed [47:0] s2_bbt3;

    assign s2_var1 = $signed(s1_var1p_reg) >>> 11;
    assign s2_bb12 = $signed(s1_bb_reg) >>> 12;
    assign s2_bbt3 = $signed(s2_bb12) * t3;

    logic        s2_valid_reg;
    logic [31:0] s2_var1_reg, s2_var2p_reg;
    logic [19:0] s2_press_reg;
    logic [15:0] s2_hum_reg;

    // Stage 3: fine temperature
    logic [31:0] s3_tfine;

    assign s3_tfine = s2_var1_reg + 32'($signed(s2_var2p_reg) >>> 14);

    logic        s3_valid_reg;
    logic [31:0] s3_tfine_reg;
    logic [19:0] s3_press_reg;
    logic [15:0] s3_hum_reg;

    // Stage 4: temperature result, first pressure and humidity products
    logic [31:0]        s4_t5, s4_temp, s4_vh;
    logic signed [33:0] s4_v1;
    logic signed [67:0] s4_v1sq;
    logic signed [49:0] s4_v1p5, s4_v1p2;
    logic signed [43:0] s4_h5vh;
    logic signed [39:0] s4_vhh6;
    logic signed [40:0] s4_vhh3;

    assign s4_t5   = (s3_tfine_reg << 2) + s3_tfine_reg + 32'd128;
    assign s4_temp = $signed(s4_t5) >>> 8;
    assign s4_v1   = $signed({{2{s3_tfine_reg[31]}}, s3_tfine_reg} - TF_OFFS_P);
    assign s4_v1sq = s4_v1 * s4_v1;
    assign s4_v1p5 = s4_v1 * p5;
    assign s4_v1p2 = s4_v1 * p2;
    assign s4_vh   = s3_tfine_reg - TF_OFFS_H;
    assign s4_h5vh = $signed(s4_vh) * h5;
    assign s4_vhh6 = $signed(s4_vh) * h6;
    assign s4_vhh3 = $signed(s4_vh) * $signed({1'b0, h3});

    logic        s4_valid_reg;
    logic [31:0] s4_temp_reg, s4_h5vh_reg, s4_vhh6_reg, s4_vhh3_reg;
    logic [63:0] s4_v1sq_reg;
    logic [49:0] s4_v1p5_reg, s4_v1p2_reg;
    logic [19:0] s4_press_reg;
    logic [15:0] s4_hum_reg;

    // Stage 5
    logic signed [79:0] s5_v1sqp6, s5_v1sqp3;
    logic [31:0]        s5_xsum, s5_x, s5_a6, s5_a3, s5_y1;

    assign s5_v1sqp6 = $signed(s4_v1sq_reg) * p6;
    assign s5_v1sqp3 = $signed(s4_v1sq_reg) * p3;
    assign s5_xsum   = {2'b00, s4_hum_reg, 14'd0} - {h4, 20'd0} - s4_h5vh_reg + 32'd16384;
    assign s5_x      = $signed(s5_xsum) >>> 15;
    assign s5_a6     = $signed(s4_vhh6_reg) >>> 10;
    assign s5_a3     = 32'($signed(s4_vhh3_reg) >>> 11) + 32'd32768;
    assign s5_y1     = s5_a6 * s5_a3;

    logic        s5_valid_reg;
    logic [31:0] s5_temp_reg, s5_x_reg, s5_y1_reg;
    logic [63:0] s5_v1sqp6_reg, s5_v1sqp3_reg;
    logic [49:0] s5_v1p5_reg, s5_v1p2_reg;
    logic [19:0] s5_press_reg;

    // Stage 6
    logic [63:0]        s6_v1p5x, s6_v1p2x, s6_v2, s6_v1b;
    logic [31:0]        s6_y2;
    logic signed [47:0] s6_yh2;

    assign s6_v1p5x = {{14{s5_v1p5_reg[49]}}, s5_v1p5_reg};
    assign s6_v1p2x = {{14{s5_v1p2_reg[49]}}, s5_v1p2_reg};
    assign s6_v2    = s5_v1sqp6_reg + (s6_v1p5x << 17) + {{13{p4[15]}}, p4, 35'd0};
    assign s6_v1b   = 64'($signed(s5_v1sqp3_reg) >>> 8) + (s6_v1p2x << 12);
    assign s6_y2    = 32'($signed(s5_y1_reg) >>> 10) + HUM_BIAS;
    assign s6_yh2   = $signed(s6_y2) * h2;

    logic        s6_valid_reg;
    logic [31:0] s6_temp_reg, s6_x_reg, s6_yh2_reg;
    logic [63:0] s6_v2_reg, s6_v1b_reg;
    logic [19:0] s6_press_reg;

    // Stage 7
    logic [63:0] s7_t;
    logic [79:0] s7_tp1;
    logic [20:0] s7_pd;
    logic [63:0] s7_pn;
    logic [31:0] s7_ysum, s7_y3, s7_vh;

    assign s7_t    = 64'h0000_8000_0000_0000 + s6_v1b_reg;
    assign s7_tp1  = s7_t * p1;
    assign s7_pd   = PRESS_BASE - {1'b0, s6_press_reg};
    assign s7_pn   = {12'd0, s7_pd, 31'd0} - s6_v2_reg;
    assign s7_ysum = s6_yh2_reg + 32'd8192;
    assign s7_y3   = $signed(s7_ysum) >>> 14;
    assign s7_vh   = s6_x_reg * s7_y3;

    logic        s7_valid_reg;
    logic [31:0] s7_temp_reg, s7_vh_reg;
    logic [63:0] s7_tp1_reg, s7_pn_reg;

    // Stage 8: divisor, dividend, humidity square
    logic [63:0] s8_d, s8_num;
    logic [31:0] s8_q, s8_sq;

    assign s8_d   = $signed(s7_tp1_reg) >>> 33;
    assign s8_num = s7_pn_reg * PRESS_K;
    assign s8_q   = $signed(s7_vh_reg) >>> 15;
    assign s8_sq  = s8_q * s8_q;

    logic        s8_valid_reg;
    logic [31:0] s8_temp_reg, s8_vh_reg, s8_sq_reg;
    logic [63:0] s8_d_reg, s8_num_reg;

    // Stage 9 logic: sign and magnitude for the divider, humidity finish
    logic [63:0] s9_ua, s9_ub;
    logic [31:0] s9_sq7, s9_sqh1, s9_vh2;
    logic [16:0] s9_hum;
    ensc_side_t  s9_side;

    assign s9_ua   = s8_num_reg[63] ? (64'd0 - s8_num_reg) : s8_num_reg;
    assign s9_ub   = s8_d_reg[63] ? (64'd0 - s8_d_reg) : s8_d_reg;
    assign s9_sq7  = $signed(s8_sq_reg) >>> 7;
    assign s9_sqh1 = s9_sq7 * {24'd0, h1};
    assign s9_vh2  = s8_vh_reg - 32'($signed(s9_sqh1) >>> 4);

    always_comb
    begin
        if (s9_vh2[31])
        begin
            s9_hum = '0;
        end
        else if (s9_vh2 > HUM_MAX)
        begin
            s9_hum = HUM_MAX[28:12];
        end
        else
        begin
            s9_hum = s9_vh2[28:12];
        end
    end

    assign s9_side.temp = s8_temp_reg;
    assign s9_side.hum  = s9_hum;
    assign s9_side.ok   = (s8_d_reg != 64'd0);
    assign s9_side.neg  = s8_num_reg[63] ^ s8_d_reg[63];

    logic        dv_valid;
    logic [63:0] dv_quot;
    ensc_side_t  dv_side;

    ensc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (s8_valid_reg),
        .dividend (s9_ua),
        .divisor  (s9_ub),
        .side_in  (s9_side),
        .out_valid(dv_valid),
        .quotient (dv_quot),
        .side_out (dv_side)
    );

    // Post-divider stages
    logic        q1_valid_reg;
    logic [63:0] q1_p_reg;
    ensc_side_t  q1_side_reg;

    logic [63:0]        q2_pq13;
    logic signed [79:0] q2_m1, q2_m2;

    assign q2_pq13 = $signed(q1_p_reg) >>> 13;
    assign q2_m1   = $signed(q2_pq13) * p9;
    assign q2_m2   = $signed(q1_p_reg) * p8;

    logic        q2_valid_reg;
    logic [63:0] q2_pq13_reg, q2_m1_reg, q2_m2_reg, q2_p_reg;
    ensc_side_t  q2_side_reg;

    // Low 64 bits of the 64 by 64 product from three 32 by 32 partial products.
    logic [63:0] q3_pp0;
    logic [31:0] q3_pp1, q3_pp2;

    assign q3_pp0 = {32'd0, q2_m1_reg[31:0]} * {32'd0, q2_pq13_reg[31:0]};
    assign q3_pp1 = q2_m1_reg[31:0] * q2_pq13_reg[63:32];
    assign q3_pp2 = q2_m1_reg[63:32] * q2_pq13_reg[31:0];

    logic        q3_valid_reg;
    logic [63:0] q3_pp0_reg, q3_m2_reg, q3_p_reg;
    logic [31:0] q3_pp12_reg;
    ensc_side_t  q3_side_reg;

    logic        q4_valid_reg;
    logic [63:0] q4_m3_reg, q4_pm_reg;
    ensc_side_t  q4_side_reg;

    logic        q5_valid_reg;
    logic [63:0] q5_s_reg;
    ensc_side_t  q5_side_reg;

    // Output formatting with saturation
    logic [63:0]  o_pf;
    ensc_result_t o_next;

    assign o_pf = 64'($signed(q5_s_reg) >>> 8) + {{44{p7[15]}}, p7, 4'd0};

    always_comb
    begin
        o_next.temp_centi = $signed(q5_side_reg.temp);
        o_next.press_ok   = q5_side_reg.ok;
        o_next.hum_q22_10 = q5_side_reg.hum;
        if (!q5_side_reg.ok || o_pf[63])
        begin
            o_next.press_q24_8 = '0;
        end
        else if (|o_pf[62:32])
        begin
            o_next.press_q24_8 = '1;
        end
        else
        begin
            o_next.press_q24_8 = o_pf[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            q1_valid_reg  <= 1'b0;
            q2_valid_reg  <= 1'b0;
            q3_valid_reg  <= 1'b0;
            q4_valid_reg  <= 1'b0;
            q5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= sample.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            q1_valid_reg  <= dv_valid;
            q2_valid_reg  <= q1_valid_reg;
            q3_valid_reg  <= q2_valid_reg;
            q4_valid_reg  <= q3_valid_reg;
            q5_valid_reg  <= q4_valid_reg;
            out_valid_reg <= q5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_var1p_reg  <= s1_at2[31:0];
            s1_bb_reg     <= s1_bb;
            s1_press_reg  <= sample.data.raw_press;
            s1_hum_reg    <= sample.data.raw_hum;

            s2_var1_reg   <= s2_var1;
            s2_var2p_reg  <= s2_bbt3[31:0];
            s2_press_reg  <= s1_press_reg;
            s2_hum_reg    <= s1_hum_reg;

            s3_tfine_reg  <= s3_tfine;
            s3_press_reg  <= s2_press_reg;
            s3_hum_reg    <= s2_hum_reg;

            s4_temp_reg   <= s4_temp;
            s4_v1sq_reg   <= s4_v1sq[63:0];
            s4_v1p5_reg   <= s4_v1p5;
            s4_v1p2_reg   <= s4_v1p2;
            s4_h5vh_reg   <= s4_h5vh[31:0];
            s4_vhh6_reg   <= s4_vhh6[31:0];
            s4_vhh3_reg   <= s4_vhh3[31:0];
            s4_press_reg  <= s3_press_reg;
            s4_hum_reg    <= s3_hum_reg;

            s5_temp_reg   <= s4_temp_reg;
            s5_v1sqp6_reg <= s5_v1sqp6[63:0];
            s5_v1sqp3_reg <= s5_v1sqp3[63:0];
            s5_v1p5_reg   <= s4_v1p5_reg;
            s5_v1p2_reg   <= s4_v1p2_reg;
            s5_x_reg      <= s5_x;
            s5_y1_reg     <= s5_y1;
            s5_press_reg  <= s4_press_reg;

            s6_temp_reg   <= s5_temp_reg;
            s6_v2_reg     <= s6_v2;
            s6_v1b_reg    <= s6_v1b;
            s6_x_reg      <= s5_x_reg;
            s6_yh2_reg    <= s6_yh2[31:0];
            s6_press_reg  <= s5_press_reg;

            s7_temp_reg   <= s6_temp_reg;
            s7_tp1_reg    <= s7_tp1[63:0];
            s7_pn_reg     <= s7_pn;
            s7_vh_reg     <= s7_vh;

            s8_temp_reg   <= s7_temp_reg;
            s8_d_reg      <= s8_d;
            s8_num_reg    <= s8_num;
            s8_vh_reg     <= s7_vh_reg;
            s8_sq_reg     <= s8_sq;

            q1_p_reg      <= dv_side.neg ? (64'd0 - dv_quot) : dv_quot;
            q1_side_reg   <= dv_side;

            q2_pq13_reg   <= q2_pq13;
            q2_m1_reg     <= q2_m1[63:0];
            q2_m2_reg     <= q2_m2[63:0];
            q2_p_reg      <= q1_p_reg;
            q2_side_reg   <= q1_side_reg;

            q3_pp0_reg    <= q3_pp0;
            q3_pp12_reg   <= q3_pp1 + q3_pp2;
            q3_m2_reg     <= q2_m2_reg;
            q3_p_reg      <= q2_p_reg;
            q3_side_reg   <= q2_side_reg;

            q4_m3_reg     <= q3_pp0_reg + {q3_pp12_reg, 32'd0};
            q4_pm_reg     <= q3_p_reg + 64'($signed(q3_m2_reg) >>> 19);
            q4_side_reg   <= q3_side_reg;

            q5_s_reg      <= q4_pm_reg + 64'($signed(q4_m3_reg) >>> 25);
            q5_side_reg   <= q4_side_reg;

            out_data_reg  <= o_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ensc_checker.sv @@
// Port-level checker for the sensor compensation block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module ensc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] press_q24_8,
    input wire logic        press_ok,
    input wire logic [16:0] hum_q22_10
);

    // A waiting result must not vanish before it is taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // With no result waiting, the pipeline must be free to take an item.
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    `ASSERT_IMPLY(a_press_zero, clk, rst_n, out_valid && !press_ok, press_q24_8 == 32'd0)

    `ASSERT_IMPLY(a_hum_range, clk, rst_n, out_valid, hum_q22_10 <= 17'd102400)

endmodule

bind env_sensor_compensation ensc_checker u_ensc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .press_q24_8(result.data.press_q24_8),
    .press_ok   (result.data.press_ok),
    .hum_q22_10 (result.data.hum_q22_10)
);

`default_nettype wire
